### sv/rau_pkg.sv
`default_nettype none
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_W = 33;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_EQUAL  = 3'd5
    } op_t;

    typedef struct packed {
        logic cap;       // latch request operands
        logic mul;       // register products
        logic comb;      // form unreduced fraction
        logic seed;      // load Euclid operands
        logic start_rem; // divider: g % h
        logic take_rem;  // g <= h, h <= remainder
        logic start_qn;  // divider: n / g
        logic take_qn;
        logic start_qd;  // divider: d / g
        logic take_qd;
        logic set_gz;    // gcd came out zero
        logic save_x;    // keep first reduced fraction (equal request)
        logic load_b;    // second fraction into n, d
        logic fin;       // load result registers
    } cmd_t;

    typedef struct packed {
        logic h_zero;
        logic g_zero;
        logic div_done;
        logic is_eq;
        logic bad_op;
    } status_t;

endpackage
`default_nettype wire

### sv/rational_arith_unit_top.sv
// Sequence: capture, products, unreduced fraction, then Euclid remainder steps on one
//   shared bit-serial divider of width IW = 2*OPERAND_WIDTH+2, then n/g and d/g.
//   A zero gcd skips both quotients; equal requests run a second reduction pass.
//   Unused op codes: go from the product step straight to the strobe.
// Throughput: one transaction at a time; busy drops in the strobe cycle; no receiver stall.
// Reset: rst_n asynchronous active low, returns the controller to idle.
`default_nettype none
module rational_arith_unit_top
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request transaction: taken when start is high and busy is low
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [2:0]                      req_type,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
    // result transaction: one-cycle strobe on valid
    output logic                                 valid,
    output logic signed [RES_W-1:0]              res_num,
    output logic signed [RES_W-1:0]              res_den,
    output logic                                 is_equal,
    output logic                                 gcd_zero
);

    cmd_t    cmd;
    status_t status;

    // Controller sequences: capture, products, unreduced fraction, then
    // Euclid remainders until the second operand is zero, then n/g and d/g unless g is zero.
    rau_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .valid  (valid),
        .cmd    (cmd),
        .status (status)
    );

    // Datapath holds operands, three multipliers, Euclid registers and the
    // shared signed divider (truncating quotient and remainder).
    rau_datapath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .req_type (req_type),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .res_num  (res_num),
        .res_den  (res_den),
        .is_equal (is_equal),
        .gcd_zero (gcd_zero)
    );

endmodule
`default_nettype wire

### sv/rau_div.sv
`default_nettype none
module rau_div
    import rau_pkg::*;
#(
    parameter int IW = 34
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [IW-1:0] dividend,
    input  wire logic signed [IW-1:0] divisor,
    output logic                      done,
    output logic signed [IW-1:0]      quo,
    output logic signed [IW-1:0]      rem
);

    localparam int CW = $clog2(IW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] q_reg, q_next;
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] dv_reg, dv_next;
    logic          nq_reg, nq_next;
    logic          nr_reg, nr_next;

    logic [IW:0]   trial;
    logic [IW:0]   diff;
    logic          ge;

    assign trial = {r_reg, q_reg[IW-1]};
    assign diff  = trial - {1'b0, dv_reg};
    assign ge    = ~diff[IW];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        dv_next   = dv_reg;
        nq_next   = nq_reg;
        nr_next   = nr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(IW);
            q_next    = dividend[IW-1] ? IW'(-dividend) : IW'(dividend);
            dv_next   = divisor[IW-1] ? IW'(-divisor) : IW'(divisor);
            r_next    = '0;
            nq_next   = dividend[IW-1] ^ divisor[IW-1];
            nr_next   = dividend[IW-1];
        end
        else if (busy_reg)
        begin
            r_next   = ge ? diff[IW-1:0] : trial[IW-1:0];
            q_next   = {q_reg[IW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        dv_reg <= dv_next;
        nq_reg <= nq_next;
        nr_reg <= nr_next;
    end

    assign done = done_reg;
    assign quo  = nq_reg ? -signed'(q_reg) : signed'(q_reg);
    assign rem  = nr_reg ? -signed'(r_reg) : signed'(r_reg);

endmodule
`default_nettype wire

### sv/rau_datapath.sv
`default_nettype none
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire cmd_t                            cmd,
    output status_t                              status,
    input  wire logic [2:0]                      req_type,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic signed [RES_W-1:0]              res_num,
    output logic signed [RES_W-1:0]              res_den,
    output logic                                 is_equal,
    output logic                                 gcd_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int IW = 2 * W + 2;

    logic [2:0]            op_reg;
    logic signed [W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]  m0_reg, m1_reg, m2_reg;
    logic signed [PW-1:0]  m0_next, m1_next, m2_next;
    logic signed [IW-1:0]  n_reg, d_reg, g_reg, h_reg;
    logic signed [IW-1:0]  n_next, d_next;
    logic signed [IW-1:0]  rn_reg, rd_reg, xn_reg, xd_reg;
    logic                  gz_reg;
    logic signed [RES_W-1:0] res_num_reg, res_den_reg;
    logic                  is_equal_reg, gcd_zero_reg;

    logic                  div_start;
    logic signed [IW-1:0]  div_a, div_b, div_q, div_r;
    logic                  div_done;

    always_comb
    begin
        m0_next = (op_reg == OP_MUL) ? an_reg * bn_reg : an_reg * bd_reg;
        m1_next = bn_reg * ad_reg;
        m2_next = ad_reg * bd_reg;
    end

    // unreduced fraction per operation
    always_comb
    begin
        n_next = '0;
        d_next = '0;
        unique case (op_reg)
            OP_REDUCE, OP_EQUAL:
            begin
                n_next = IW'(an_reg);
                d_next = IW'(ad_reg);
            end
            OP_ADD:
            begin
                if (ad_reg == bd_reg)
                begin
                    n_next = IW'(an_reg) + IW'(bn_reg);
                    d_next = IW'(ad_reg);
                end
                else
                begin
                    n_next = IW'(m0_reg) + IW'(m1_reg);
                    d_next = IW'(m2_reg);
                end
            end
            OP_SUB:
            begin
                if (ad_reg == bd_reg)
                begin
                    n_next = IW'(an_reg) - IW'(bn_reg);
                    d_next = IW'(ad_reg);
                end
                else
                begin
                    n_next = IW'(m0_reg) - IW'(m1_reg);
                    d_next = IW'(m2_reg);
                end
            end
            OP_MUL:
            begin
                n_next = IW'(m0_reg);
                d_next = IW'(m2_reg);
            end
            OP_DIV:
            begin
                n_next = IW'(m0_reg);
                d_next = IW'(m1_reg);
            end
            default:
            begin
                n_next = '0;
                d_next = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start = cmd.start_rem | cmd.start_qn | cmd.start_qd;
        div_a     = cmd.start_rem ? g_reg : (cmd.start_qn ? n_reg : d_reg);
        div_b     = cmd.start_rem ? h_reg : g_reg;
    end

    rau_div #(
        .IW(IW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quo      (div_q),
        .rem      (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg <= req_type;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        if (cmd.mul)
        begin
            m0_reg <= m0_next;
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
        if (cmd.comb)
        begin
            n_reg <= n_next;
            d_reg <= d_next;
        end
        if (cmd.load_b)
        begin
            n_reg <= IW'(bn_reg);
            d_reg <= IW'(bd_reg);
        end
        if (cmd.seed)
        begin
            g_reg <= (n_reg > d_reg) ? n_reg : d_reg;
            h_reg <= (n_reg > d_reg) ? d_reg : n_reg;
        end
        if (cmd.take_rem)
        begin
            g_reg <= h_reg;
            h_reg <= div_r;
        end
        if (cmd.take_qn)
            rn_reg <= div_q;
        if (cmd.take_qd)
            rd_reg <= div_q;
        if (cmd.save_x)
        begin
            xn_reg <= rn_reg;
            xd_reg <= rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gz_reg       <= 1'b0;
            res_num_reg  <= '0;
            res_den_reg  <= '0;
            is_equal_reg <= 1'b0;
            gcd_zero_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cap)
                gz_reg <= 1'b0;
            else if (cmd.set_gz)
                gz_reg <= 1'b1;
            if (cmd.fin)
            begin
                if (op_reg == OP_EQUAL || gz_reg)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                end
                else
                begin
                    res_num_reg <= RES_W'(rn_reg);
                    res_den_reg <= RES_W'(rd_reg);
                end
                is_equal_reg <= (op_reg == OP_EQUAL) && !gz_reg &&
                                (xn_reg == rn_reg) && (xd_reg == rd_reg);
                gcd_zero_reg <= gz_reg;
            end
        end
    end

    always_comb
    begin
        status.h_zero   = (h_reg == '0);
        status.g_zero   = (g_reg == '0);
        status.div_done = div_done;
        status.is_eq    = (op_reg == OP_EQUAL);
        status.bad_op   = (op_reg > OP_EQUAL);
    end

    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign is_equal = is_equal_reg;
    assign gcd_zero = gcd_zero_reg;

endmodule
`default_nettype wire

### sv/rau_ctrl.sv
`default_nettype none
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    output logic         valid,
    output cmd_t         cmd,
    input  wire status_t status
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_COMB = 10'b0000000100,
        S_SEED = 10'b0000001000,
        S_CHK  = 10'b0000010000,
        S_REM  = 10'b0000100000,
        S_QN   = 10'b0001000000,
        S_QD   = 10'b0010000000,
        S_NEXT = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        valid_next = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.cap    = 1'b1;
                    pass_next  = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = status.bad_op ? S_FIN : S_COMB;
            end
            S_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = S_SEED;
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!status.h_zero)
                begin
                    cmd.start_rem = 1'b1;
                    state_next    = S_REM;
                end
                else if (status.g_zero)
                begin
                    cmd.set_gz = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.start_qn = 1'b1;
                    state_next   = S_QN;
                end
            end
            S_REM:
            begin
                if (status.div_done)
                begin
                    cmd.take_rem = 1'b1;
                    state_next   = S_CHK;
                end
            end
            S_QN:
            begin
                if (status.div_done)
                begin
                    cmd.take_qn  = 1'b1;
                    cmd.start_qd = 1'b1;
                    state_next   = S_QD;
                end
            end
            S_QD:
            begin
                if (status.div_done)
                begin
                    cmd.take_qd = 1'b1;
                    state_next  = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (status.is_eq && !pass_reg)
                begin
                    cmd.save_x = 1'b1;
                    cmd.load_b = 1'b1;
                    pass_next  = 1'b1;
                    state_next = S_SEED;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            valid_reg <= valid_next;
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign valid = valid_reg;

endmodule
`default_nettype wire

### sim/rational_arith_unit_top_test.sv
module rational_arith_unit_top_test
    import rau_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = OPERAND_WIDTH_DEF;
    localparam int NUM_RANDOM = 1800;

    // one request row; chk marks rows whose result is typed in
    typedef struct {
        logic [2:0]          op;
        logic signed [15:0]  an;
        logic signed [15:0]  ad;
        logic signed [15:0]  bn;
        logic signed [15:0]  bd;
        bit                  chk;
        logic signed [32:0]  rn;
        logic signed [32:0]  rd;
        logic                eq;
        logic                gz;
    } req_row_t;

    typedef struct {
        logic signed [32:0] rn;
        logic signed [32:0] rd;
        logic               eq;
        logic               gz;
    } frac_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           req_type;
    logic signed [OW-1:0] a_num;
    logic signed [OW-1:0] a_den;
    logic signed [OW-1:0] b_num;
    logic signed [OW-1:0] b_den;
    logic                 valid;
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                 is_equal;
    logic                 gcd_zero;

    frac_res_t pending_results[$];
    int        err_count;
    bit        stim_done;

    rational_arith_unit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .valid    (valid),
        .res_num  (res_num),
        .res_den  (res_den),
        .is_equal (is_equal),
        .gcd_zero (gcd_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Euclid reduction: larger part (signed) seeds the loop, truncating
    // remainder, gcd sign kept. Returns 0 when gcd is zero.
    function automatic bit reduce_pair(input longint n, input longint d,
                                       output longint rn, output longint rd);
        longint g;
        longint h;
        longint r;
        if (n > d)
        begin
            g = n;
            h = d;
        end
        else
        begin
            g = d;
            h = n;
        end
        while (h != 0)
        begin
            r = g % h;
            g = h;
            h = r;
        end
        if (g == 0)
        begin
            rn = 0;
            rd = 0;
            return 0;
        end
        rn = n / g;
        rd = d / g;
        return 1;
    endfunction

    function automatic frac_res_t predict_fraction(input logic [2:0] op,
        input logic signed [15:0] an_i, input logic signed [15:0] ad_i,
        input logic signed [15:0] bn_i, input logic signed [15:0] bd_i);
        frac_res_t res;
        longint an;
        longint ad;
        longint bn;
        longint bd;
        longint n;
        longint d;
        longint xn;
        longint xd;
        longint yn;
        longint yd;
        bit okx;
        bit oky;
        res = '{default: '0};
        an = an_i;
        ad = ad_i;
        bn = bn_i;
        bd = bd_i;
        n = 0;
        d = 0;
        if (op > OP_EQUAL)
            return res;
        if (op == OP_EQUAL)
        begin
            okx = reduce_pair(an, ad, xn, xd);
            oky = reduce_pair(bn, bd, yn, yd);
            if (!okx || !oky)
                res.gz = 1'b1;
            else if (xn == yn && xd == yd)
                res.eq = 1'b1;
            return res;
        end
        case (op)
            OP_REDUCE:
            begin
                n = an;
                d = ad;
            end
            OP_ADD:
            begin
                if (ad == bd)
                begin
                    n = an + bn;
                    d = ad;
                end
                else
                begin
                    n = an * bd + bn * ad;
                    d = ad * bd;
                end
            end
            OP_SUB:
            begin
                if (ad == bd)
                begin
                    n = an - bn;
                    d = ad;
                end
                else
                begin
                    n = an * bd - bn * ad;
                    d = ad * bd;
                end
            end
            OP_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            default:
            begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        if (!reduce_pair(n, d, xn, xd))
            res.gz = 1'b1;
        res.rn = xn[32:0];
        res.rd = xd[32:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Directed rows: extremes, all ops, equal denominators, zero gcd,
    // unused op codes. Typed results only where obvious.
    req_row_t dir_rows[$];

    function automatic req_row_t row(input logic [2:0] op, input int an, input int ad,
        input int bn, input int bd, input bit chk, input longint rn, input longint rd,
        input bit eq, input bit gz);
        req_row_t r;
        r.op = op;
        r.an = an[15:0];
        r.ad = ad[15:0];
        r.bn = bn[15:0];
        r.bd = bd[15:0];
        r.chk = chk;
        r.rn = rn[32:0];
        r.rd = rd[32:0];
        r.eq = eq;
        r.gz = gz;
        return r;
    endfunction

    initial
    begin
        dir_rows.push_back(row(OP_REDUCE, 0, 0, 0, 0, 1, 0, 0, 0, 1));
        dir_rows.push_back(row(OP_REDUCE, 6, 4, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_REDUCE, -6, 4, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_REDUCE, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_REDUCE, 0, -7, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_REDUCE, -32768, 32767, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_REDUCE, -32768, -32768, -1, -1, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ADD, 1, 3, 1, 3, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ADD, 1, 2, 1, 3, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ADD, 32767, 32767, 32767, -32768, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_SUB, 3, 5, 3, 5, 1, 0, 1, 0, 0));
        dir_rows.push_back(row(OP_SUB, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_SUB, 2, 7, -3, 4, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_MUL, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_MUL, 0, 0, 9, 9, 1, 0, 0, 0, 1));
        dir_rows.push_back(row(OP_MUL, 32767, 2, -32768, 3, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_DIV, 3, 4, 5, 6, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_DIV, 1, 0, 0, 1, 1, 1, 0, 0, 0));
        dir_rows.push_back(row(OP_DIV, -32768, 1, 1, -32768, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_EQUAL, 2, 4, 1, 2, 1, 0, 0, 1, 0));
        dir_rows.push_back(row(OP_EQUAL, 2, 4, -1, -2, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_EQUAL, 0, 0, 1, 2, 1, 0, 0, 0, 1));
        dir_rows.push_back(row(OP_EQUAL, 1, 3, 0, 0, 1, 0, 0, 0, 1));
        dir_rows.push_back(row(3'd6, 5, 6, 7, 8, 1, 0, 0, 0, 0));
        dir_rows.push_back(row(3'd7, -1, -1, -1, -1, 1, 0, 0, 0, 0));
    end

    // Drive one request at the falling edge and hold it until taken;
    // start stays high, the caller drops it for a gap.
    task automatic send_request(input req_row_t r);
        frac_res_t exp_res;
        if (r.chk)
        begin
            exp_res.rn = r.rn;
            exp_res.rd = r.rd;
            exp_res.eq = r.eq;
            exp_res.gz = r.gz;
        end
        else
            exp_res = predict_fraction(r.op, r.an, r.ad, r.bn, r.bd);
        start    <= 1'b1;
        req_type <= r.op;
        a_num    <= r.an;
        a_den    <= r.ad;
        b_num    <= r.bn;
        b_den    <= r.bd;
        // accepted on the rising edge where busy is low
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(exp_res);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3, 4: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Stimulus: directed table, then random requests in bursts.
    initial
    begin
        req_row_t r;
        int burst;
        err_count = 0;
        stim_done = 0;
        start    = 1'b0;
        req_type = '0;
        a_num    = '0;
        a_den    = '0;
        b_num    = '0;
        b_den    = '0;
        rst_n    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (dir_rows[i])
            send_request(dir_rows[i]);
        burst = 0;
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 300)) @(negedge clk);
                end
            end
            burst--;
            r.op  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
            r.an  = rand_operand();
            r.ad  = rand_operand();
            r.bn  = rand_operand();
            r.bd  = ($urandom_range(0, 3) == 0) ? r.ad : rand_operand();
            r.chk = 0;
            send_request(r);
        end
        start <= 1'b0;
        stim_done = 1;
    end

    // Result checker: every strobe matches the oldest expectation.
    always @(posedge clk)
    begin
        frac_res_t e;
        if (rst_n && valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                err_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (res_num !== e.rn)
                    report_mismatch("res_num", res_num, e.rn);
                if (res_den !== e.rd)
                    report_mismatch("res_den", res_den, e.rd);
                if (is_equal !== e.eq)
                    report_mismatch("is_equal", is_equal, e.eq);
                if (gcd_zero !== e.gz)
                    report_mismatch("gcd_zero", gcd_zero, e.gz);
            end
        end
    end

    // End of run: drain, settle, then verdict.
    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: ~2000 items, each at worst-case request time plus the longest gap, several times over.
    initial
    begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
